// ===== src/dllm_pkg.sv =====
// Shared constants, types and helpers for the doubly linked list manager.
`default_nettype none
package dllm_pkg;

	localparam int POOL_NODES = 64;
	localparam int IDX_W      = $clog2(POOL_NODES);
	localparam int LINK_W     = $clog2(POOL_NODES + 1);
	localparam int CNT_W      = LINK_W;
	localparam int MODE_W     = 4;

	localparam logic [LINK_W-1:0] NONE_NODE = LINK_W'(POOL_NODES);
	localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(POOL_NODES);

	// Operation codes as they arrive on the mode field
	localparam logic [MODE_W-1:0] MODE_INS_HEAD   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_INS_TAIL   = 4'd1;
	localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 4'd2;
	localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 4'd3;
	localparam logic [MODE_W-1:0] MODE_REMOVE     = 4'd4;
	localparam logic [MODE_W-1:0] MODE_POP_HEAD   = 4'd5;
	localparam logic [MODE_W-1:0] MODE_POP_TAIL   = 4'd6;
	localparam logic [MODE_W-1:0] MODE_PEEK_HEAD  = 4'd7;
	localparam logic [MODE_W-1:0] MODE_PEEK_TAIL  = 4'd8;
	localparam logic [MODE_W-1:0] MODE_NEXT       = 4'd9;
	localparam logic [MODE_W-1:0] MODE_PREV       = 4'd10;
	localparam logic [MODE_W-1:0] MODE_CLEAR      = 4'd11;

	typedef enum logic [3:0] {
		OP_INS_HEAD,
		OP_INS_TAIL,
		OP_INS_AFTER,
		OP_INS_BEFORE,
		OP_REMOVE,
		OP_POP_HEAD,
		OP_POP_TAIL,
		OP_PEEK_HEAD,
		OP_PEEK_TAIL,
		OP_NEXT,
		OP_PREV,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] n;
		logic [IDX_W-1:0] p;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_A,
		ST_B,
		ST_C
	} step_t;

	typedef struct packed {
		logic [LINK_W-1:0] node;
		logic [CNT_W-1:0]  total;
		logic              empty;
	} result_t;

	function automatic logic is_node(input logic [LINK_W-1:0] v);
		return v < NONE_NODE;
	endfunction

endpackage
`default_nettype wire

// ===== src/dllm_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module dllm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== src/dllm_front.sv =====
// Front end: accepts items, decodes the mode and queues commands.
`default_nettype none
module dllm_front
	import dllm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [IDX_W-1:0]  node_index,
	input  wire logic [IDX_W-1:0]  position_index,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output cmd_t                   cmd
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       push;
	logic       pop;

	// Decode the mode; every index field is in the pool by its width
	always_comb begin
		dec.n = node_index;
		dec.p = position_index;
		unique case (mode)
			MODE_INS_HEAD:   dec.op = OP_INS_HEAD;
			MODE_INS_TAIL:   dec.op = OP_INS_TAIL;
			MODE_INS_AFTER:  dec.op = OP_INS_AFTER;
			MODE_INS_BEFORE: dec.op = OP_INS_BEFORE;
			MODE_REMOVE:     dec.op = OP_REMOVE;
			MODE_POP_HEAD:   dec.op = OP_POP_HEAD;
			MODE_POP_TAIL:   dec.op = OP_POP_TAIL;
			MODE_PEEK_HEAD:  dec.op = OP_PEEK_HEAD;
			MODE_PEEK_TAIL:  dec.op = OP_PEEK_TAIL;
			MODE_NEXT:       dec.op = OP_NEXT;
			MODE_PREV:       dec.op = OP_PREV;
			MODE_CLEAR:      dec.op = OP_CLEAR;
			default:         dec.op = OP_NOP;
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	// Store the decoded item
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/dllm_back.sv =====
// Back end: carries out list operations on the link RAMs, holds head, tail and count.
`default_nettype none
module dllm_back
	import dllm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	output logic      out_valid,
	input  wire logic out_ready,
	output result_t   result
);

	step_t             step_q, step_d;
	cmd_t              cmd_q;
	logic [LINK_W-1:0] t_q;
	logic [LINK_W-1:0] t_d;
	logic [LINK_W-1:0] head_q, head_d;
	logic [LINK_W-1:0] tail_q, tail_d;
	logic [CNT_W-1:0]  size_q, size_d;
	logic [POOL_NODES-1:0] nv_q;
	logic [POOL_NODES-1:0] pv_q;
	logic              nvr_q;
	logic              pvr_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              n_we, p_we;
	logic [IDX_W-1:0]  n_waddr, p_waddr, n_raddr, p_raddr;
	logic [LINK_W-1:0] n_wdata, p_wdata, n_rdata, p_rdata;
	logic [LINK_W-1:0] rd_next, rd_prev;
	logic [LINK_W-1:0] res;
	logic              fin;
	logic              take;
	logic              stall;
	logic [LINK_W-1:0] n_link, p_link;

	dllm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_next_ram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_rdata)
	);

	dllm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_prev_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	// Never-written entries read as none
	assign rd_next = nvr_q ? n_rdata : NONE_NODE;
	assign rd_prev = pvr_q ? p_rdata : NONE_NODE;
	assign n_link  = LINK_W'(cmd_q.n);
	assign p_link  = LINK_W'(cmd_q.p);

	assign stall     = out_valid_q && !out_ready;
	assign cmd_ready = (step_q == ST_IDLE) && !stall;
	assign out_valid = out_valid_q;
	assign result    = out_q;

	// Pick read addresses; reads issued in step A land in step B
	always_comb begin
		unique case (cmd_q.op)
			OP_INS_AFTER: n_raddr = cmd_q.p;
			OP_NEXT:      n_raddr = cmd_q.n;
			default:      n_raddr = t_q[IDX_W-1:0];
		endcase
		unique case (cmd_q.op)
			OP_INS_BEFORE: p_raddr = cmd_q.p;
			OP_PREV:       p_raddr = cmd_q.n;
			default:       p_raddr = t_q[IDX_W-1:0];
		endcase
	end

	// Target node of remove and pop, taken at dispatch: the node index for remove, head or tail for pop
	always_comb begin
		unique case (cmd.op)
			OP_POP_HEAD: t_d = head_q;
			OP_POP_TAIL: t_d = tail_q;
			default:     t_d = LINK_W'(cmd.n);
		endcase
	end

	// Step sequencer: next state, link writes and list registers
	always_comb begin
		step_d  = step_q;
		head_d  = head_q;
		tail_d  = tail_q;
		size_d  = size_q;
		n_we    = 1'b0;
		p_we    = 1'b0;
		n_waddr = '0;
		p_waddr = '0;
		n_wdata = NONE_NODE;
		p_wdata = NONE_NODE;
		res     = NONE_NODE;
		fin     = 1'b0;
		take    = 1'b0;
		if (!stall) begin
			unique case (step_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						take   = 1'b1;
						step_d = ST_A;
					end
				end
				ST_A: begin
					step_d = ST_B;
					unique case (cmd_q.op)
						OP_INS_HEAD: begin
							p_we = 1'b1; p_waddr = cmd_q.n; p_wdata = NONE_NODE;
							n_we = 1'b1; n_waddr = cmd_q.n; n_wdata = head_q;
						end
						OP_INS_TAIL: begin
							n_we = 1'b1; n_waddr = cmd_q.n; n_wdata = NONE_NODE;
							p_we = 1'b1; p_waddr = cmd_q.n; p_wdata = tail_q;
						end
						OP_INS_AFTER: begin
							p_we = 1'b1; p_waddr = cmd_q.n; p_wdata = p_link;
						end
						OP_INS_BEFORE: begin
							n_we = 1'b1; n_waddr = cmd_q.n; n_wdata = p_link;
						end
						OP_REMOVE, OP_POP_HEAD, OP_POP_TAIL: begin
							// popping an empty list changes nothing
							if (!is_node(t_q)) begin
								fin    = 1'b1;
								step_d = ST_IDLE;
							end
						end
						OP_PEEK_HEAD: begin
							res = head_q; fin = 1'b1; step_d = ST_IDLE;
						end
						OP_PEEK_TAIL: begin
							res = tail_q; fin = 1'b1; step_d = ST_IDLE;
						end
						OP_NEXT, OP_PREV: begin
						end
						OP_CLEAR: begin
							head_d = NONE_NODE;
							tail_d = NONE_NODE;
							size_d = '0;
							fin    = 1'b1;
							step_d = ST_IDLE;
						end
						default: begin
							fin    = 1'b1;
							step_d = ST_IDLE;
						end
					endcase
				end
				ST_B: begin
					step_d = ST_C;
					unique case (cmd_q.op)
						OP_INS_HEAD: begin
							if (is_node(head_q)) begin
								p_we = 1'b1; p_waddr = head_q[IDX_W-1:0]; p_wdata = n_link;
							end else begin
								tail_d = n_link;
							end
							head_d = n_link;
							if (size_q < CNT_MAX) size_d = size_q + CNT_W'(1);
							fin    = 1'b1;
							step_d = ST_IDLE;
						end
						OP_INS_TAIL: begin
							if (is_node(tail_q)) begin
								n_we = 1'b1; n_waddr = tail_q[IDX_W-1:0]; n_wdata = n_link;
							end else begin
								head_d = n_link;
							end
							tail_d = n_link;
							if (size_q < CNT_MAX) size_d = size_q + CNT_W'(1);
							fin    = 1'b1;
							step_d = ST_IDLE;
						end
						OP_INS_AFTER: begin
							n_we = 1'b1; n_waddr = cmd_q.n; n_wdata = rd_next;
							if (is_node(rd_next)) begin
								p_we = 1'b1; p_waddr = rd_next[IDX_W-1:0]; p_wdata = n_link;
							end else begin
								tail_d = n_link;
							end
						end
						OP_INS_BEFORE: begin
							p_we = 1'b1; p_waddr = cmd_q.n; p_wdata = rd_prev;
							if (is_node(rd_prev)) begin
								n_we = 1'b1; n_waddr = rd_prev[IDX_W-1:0]; n_wdata = n_link;
							end else begin
								head_d = n_link;
							end
						end
						OP_REMOVE, OP_POP_HEAD, OP_POP_TAIL: begin
							// bridge the neighbors around the target
							if (is_node(rd_prev)) begin
								n_we = 1'b1; n_waddr = rd_prev[IDX_W-1:0]; n_wdata = rd_next;
							end else begin
								head_d = rd_next;
							end
							if (is_node(rd_next)) begin
								p_we = 1'b1; p_waddr = rd_next[IDX_W-1:0]; p_wdata = rd_prev;
							end else begin
								tail_d = rd_prev;
							end
						end
						OP_NEXT: begin
							res = rd_next; fin = 1'b1; step_d = ST_IDLE;
						end
						OP_PREV: begin
							res = rd_prev; fin = 1'b1; step_d = ST_IDLE;
						end
						default: begin
							fin    = 1'b1;
							step_d = ST_IDLE;
						end
					endcase
				end
				ST_C: begin
					fin    = 1'b1;
					step_d = ST_IDLE;
					unique case (cmd_q.op)
						OP_INS_AFTER: begin
							n_we = 1'b1; n_waddr = cmd_q.p; n_wdata = n_link;
							if (size_q < CNT_MAX) size_d = size_q + CNT_W'(1);
						end
						OP_INS_BEFORE: begin
							p_we = 1'b1; p_waddr = cmd_q.p; p_wdata = n_link;
							if (size_q < CNT_MAX) size_d = size_q + CNT_W'(1);
						end
						OP_REMOVE, OP_POP_HEAD, OP_POP_TAIL: begin
							n_we = 1'b1; n_waddr = t_q[IDX_W-1:0]; n_wdata = NONE_NODE;
							p_we = 1'b1; p_waddr = t_q[IDX_W-1:0]; p_wdata = NONE_NODE;
							if (size_q != '0) size_d = size_q - CNT_W'(1);
							if (cmd_q.op != OP_REMOVE) res = t_q;
						end
						default: begin
						end
					endcase
				end
				default: begin
					step_d = ST_IDLE;
				end
			endcase
		end
	end

	// Latch the dispatched command and the result item
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd;
			t_q   <= t_d;
		end
		if (fin) begin
			out_q.node  <= res;
			out_q.total <= size_d;
			out_q.empty <= !is_node(head_d);
		end
	end

	// Hold control state, list registers, written marks and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			head_q      <= NONE_NODE;
			tail_q      <= NONE_NODE;
			size_q      <= '0;
			nv_q        <= '0;
			pv_q        <= '0;
			nvr_q       <= 1'b0;
			pvr_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			head_q <= head_d;
			tail_q <= tail_d;
			size_q <= size_d;
			if (n_we) nv_q[n_waddr] <= 1'b1;
			if (p_we) pv_q[p_waddr] <= 1'b1;
			nvr_q <= nv_q[n_raddr];
			pvr_q <= pv_q[p_raddr];
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/doubly_linked_list_manager_top.sv =====
// Top level of the doubly linked list manager: front queue plus back-end executor.
// One list over a pool of 64 nodes; each item yields exactly one result item, in order.
// The front end queues up to two items, so input is taken while the back end works or a
// result waits. The back end takes an item from the queue when idle, then ends peek, clear
// and unknown modes in step A, insert at head or tail and next-of and prev-of in step B,
// and insert after or before, remove and pop in step C (a pop of an empty list in step A);
// a result that waits unaccepted holds it in its step. The steps are set by the single write
// port of each link RAM and its registered read. Link entries never written read as none.
`default_nettype none
module doubly_linked_list_manager_top
	import dllm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [IDX_W-1:0]  node_index,
	input  wire logic [IDX_W-1:0]  position_index,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [LINK_W-1:0]      result_node,
	output logic [CNT_W-1:0]       node_total,
	output logic                   list_empty
);

	logic    cmd_valid;
	logic    cmd_ready;
	cmd_t    cmd;
	result_t result;

	dllm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .node_index(node_index), .position_index(position_index),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	dllm_back u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.out_valid(out_valid), .out_ready(out_ready), .result(result)
	);

	assign result_node = result.node;
	assign node_total  = result.total;
	assign list_empty  = result.empty;

endmodule
`default_nettype wire

// ===== src/dllm_checker.sv =====
// Port-level checks for the doubly linked list manager, bound to the top level.
`default_nettype none
module dllm_checker
	import dllm_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [LINK_W-1:0] result_node,
	input wire logic [CNT_W-1:0]  node_total,
	input wire logic              list_empty
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_node)
			&& $stable(node_total) && $stable(list_empty))
		else $error("stalled result changed");

	// Result node is a pool node or none
	a_node_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_node <= NONE_NODE)
		else $error("result node out of range");

	// Count never exceeds the pool
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> node_total <= CNT_MAX)
		else $error("node total out of range");

endmodule

bind doubly_linked_list_manager_top dllm_checker u_dllm_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.result_node(result_node), .node_total(node_total), .list_empty(list_empty)
);
`default_nettype wire

// ===== test/doubly_linked_list_manager_top_tb.sv =====
// Testbench for the doubly linked list manager: queued driver, monitor and list predictor.
`default_nettype none
module doubly_linked_list_manager_top_tb
	import dllm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  n;
		logic [IDX_W-1:0]  p;
	} op_item_t;

	typedef struct packed {
		logic [LINK_W-1:0] node;
		logic [CNT_W-1:0]  total;
		logic              empty;
	} answer_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [MODE_W-1:0] mode;
	logic [IDX_W-1:0]  node_index;
	logic [IDX_W-1:0]  position_index;
	logic              out_valid;
	logic              out_ready;
	logic [LINK_W-1:0] result_node;
	logic [CNT_W-1:0]  node_total;
	logic              list_empty;

	op_item_t pending_ops[$];
	answer_t  expected_answers[$];
	int       send_idle_pct;
	int       recv_stall_pct;
	int       mismatch_count;
	int       answers_seen;
	int       ops_sent;
	bit       phase_done;
	bit       in_taken;

	// Predictor copy of the list
	logic [LINK_W-1:0] nxt[POOL_NODES];
	logic [LINK_W-1:0] prv[POOL_NODES];
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] tail_q;
	logic [CNT_W-1:0]  size_q;

	// Model-side view of which nodes are linked, for well-formed stimulus
	bit     in_list[POOL_NODES];
	int     member_cnt;

	doubly_linked_list_manager_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .node_index(node_index), .position_index(position_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_node(result_node), .node_total(node_total), .list_empty(list_empty)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic bit linked(logic [LINK_W-1:0] v);
		return v < NONE_NODE;
	endfunction

	function automatic void grow();
		if (size_q < CNT_MAX) size_q = size_q + 1'b1;
	endfunction

	function automatic void unlink(logic [LINK_W-1:0] k);
		if (linked(prv[k])) nxt[prv[k]] = nxt[k];
		else head_q = nxt[k];
		if (linked(nxt[k])) prv[nxt[k]] = prv[k];
		else tail_q = prv[k];
		nxt[k] = NONE_NODE;
		prv[k] = NONE_NODE;
		if (size_q > 0) size_q = size_q - 1'b1;
	endfunction

	// Advance the list copy by one item and return the expected answer
	function automatic answer_t list_predict(op_item_t it);
		answer_t a;
		logic [LINK_W-1:0] k;
		logic [LINK_W-1:0] q;
		k = LINK_W'(it.n);
		q = LINK_W'(it.p);
		a.node = NONE_NODE;
		case (it.mode)
			MODE_INS_HEAD: begin
				prv[k] = NONE_NODE;
				nxt[k] = head_q;
				if (linked(head_q)) prv[head_q] = k;
				else tail_q = k;
				head_q = k;
				grow();
			end
			MODE_INS_TAIL: begin
				nxt[k] = NONE_NODE;
				prv[k] = tail_q;
				if (linked(tail_q)) nxt[tail_q] = k;
				else head_q = k;
				tail_q = k;
				grow();
			end
			MODE_INS_AFTER: begin
				prv[k] = q;
				nxt[k] = nxt[q];
				if (linked(nxt[q])) prv[nxt[q]] = k;
				else tail_q = k;
				nxt[q] = k;
				grow();
			end
			MODE_INS_BEFORE: begin
				nxt[k] = q;
				prv[k] = prv[q];
				if (linked(prv[q])) nxt[prv[q]] = k;
				else head_q = k;
				prv[q] = k;
				grow();
			end
			MODE_REMOVE: unlink(k);
			MODE_POP_HEAD: if (linked(head_q)) begin
				a.node = head_q;
				unlink(head_q);
			end
			MODE_POP_TAIL: if (linked(tail_q)) begin
				a.node = tail_q;
				unlink(tail_q);
			end
			MODE_PEEK_HEAD: a.node = head_q;
			MODE_PEEK_TAIL: a.node = tail_q;
			MODE_NEXT: a.node = nxt[k];
			MODE_PREV: a.node = prv[k];
			MODE_CLEAR: begin
				head_q = NONE_NODE;
				tail_q = NONE_NODE;
				size_q = '0;
			end
			default: ;
		endcase
		a.total = size_q;
		a.empty = !linked(head_q);
		return a;
	endfunction

	// Record each item accepted at this edge and advance the predictor
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && in_ready;
		if (in_taken) begin
			expected_answers.push_back(list_predict({mode, node_index, position_index}));
			ops_sent++;
		end
	end

	// Drive items at the falling edge; hold valid until accepted
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if ((!in_valid || in_taken) && pending_ops.size() > 0
					&& $urandom_range(99) >= send_idle_pct) begin
				op_item_t it;
				it = pending_ops.pop_front();
				in_valid       <= 1'b1;
				mode           <= it.mode;
				node_index     <= it.n;
				position_index <= it.p;
			end else if (in_valid && in_taken) begin
				in_valid <= 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result item with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			answer_t exp_a;
			answers_seen++;
			if (expected_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result item node=%0d total=%0d empty=%0d",
						result_node, node_total, list_empty);
			end else begin
				exp_a = expected_answers.pop_front();
				if (exp_a !== {result_node, node_total, list_empty}) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp node=%0d total=%0d empty=%0d, got %0d %0d %0d",
							exp_a.node, exp_a.total, exp_a.empty,
							result_node, node_total, list_empty);
				end
			end
		end
	end

	function automatic int pick_member();
		int k;
		k = $urandom_range(POOL_NODES - 1);
		while (!in_list[k]) k = (k + 1) % POOL_NODES;
		return k;
	endfunction

	function automatic int pick_free();
		int k;
		k = $urandom_range(POOL_NODES - 1);
		while (in_list[k]) k = (k + 1) % POOL_NODES;
		return k;
	endfunction

	// Queue one item; the caller tracks membership so later items stay well formed
	task automatic add_op(logic [MODE_W-1:0] m, int k, int q);
		pending_ops.push_back({m, IDX_W'(k), IDX_W'(q)});
	endtask

	// Queue one random item, mostly legal for the current membership
	task automatic add_random_op();
		int r;
		int k;
		int q;
		r = $urandom_range(99);
		k = $urandom_range(POOL_NODES - 1);
		q = $urandom_range(POOL_NODES - 1);
		if (r < 40 && member_cnt < POOL_NODES) begin
			k = pick_free();
			if (member_cnt > 0) q = pick_member();
			case ($urandom_range(3))
				0: add_op(MODE_INS_HEAD, k, q);
				1: add_op(MODE_INS_TAIL, k, q);
				2: add_op(member_cnt > 0 ? MODE_INS_AFTER : MODE_INS_TAIL, k, q);
				default: add_op(member_cnt > 0 ? MODE_INS_BEFORE : MODE_INS_HEAD, k, q);
			endcase
			in_list[k] = 1;
			member_cnt++;
		end else if (r < 50 && member_cnt > 0) begin
			k = pick_member();
			add_op(MODE_REMOVE, k, q);
			in_list[k] = 0;
			member_cnt--;
		end else if (r < 60) begin
			// pops: a clear follows when the list has members, so membership stays known
			add_op($urandom_range(1) ? MODE_POP_HEAD : MODE_POP_TAIL, k, q);
			if (member_cnt > 0) begin
				add_op(MODE_CLEAR, k, q);
				for (int i = 0; i < POOL_NODES; i++) in_list[i] = 0;
				member_cnt = 0;
			end
		end else if (r < 62) begin
			add_op(MODE_CLEAR, k, q);
			for (int i = 0; i < POOL_NODES; i++) in_list[i] = 0;
			member_cnt = 0;
		end else if (r < 64) begin
			add_op(MODE_W'($urandom_range(15, 12)), k, q);
		end else begin
			add_op(MODE_W'($urandom_range(10, 7)), k, q);
		end
	endtask

	task automatic wait_drain();
		while (pending_ops.size() > 0 || in_valid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		mode = '0;
		node_index = '0;
		position_index = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatch_count = 0;
		answers_seen = 0;
		ops_sent = 0;
		for (int i = 0; i < POOL_NODES; i++) begin
			nxt[i] = NONE_NODE;
			prv[i] = NONE_NODE;
			in_list[i] = 0;
		end
		head_q = NONE_NODE;
		tail_q = NONE_NODE;
		size_q = '0;
		member_cnt = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty pops and peeks, extremes, every mode, stale links after clear
		add_op(MODE_POP_HEAD, 0, 0);
		add_op(MODE_POP_TAIL, 63, 63);
		add_op(MODE_PEEK_HEAD, 0, 0);
		add_op(MODE_PEEK_TAIL, 0, 0);
		add_op(MODE_INS_HEAD, 0, 0);
		add_op(MODE_INS_TAIL, 63, 0);
		add_op(MODE_INS_AFTER, 21, 0);
		add_op(MODE_INS_BEFORE, 42, 0);
		add_op(MODE_INS_AFTER, 5, 63);
		add_op(MODE_INS_BEFORE, 6, 42);
		add_op(MODE_NEXT, 0, 63);
		add_op(MODE_PREV, 0, 63);
		add_op(MODE_REMOVE, 6, 0);
		add_op(MODE_REMOVE, 5, 0);
		add_op(MODE_POP_HEAD, 0, 0);
		add_op(MODE_POP_TAIL, 0, 0);
		add_op(MODE_PEEK_HEAD, 0, 0);
		add_op(MODE_PEEK_TAIL, 0, 0);
		add_op(MODE_CLEAR, 0, 0);
		add_op(MODE_NEXT, 0, 0);
		add_op(MODE_PREV, 21, 0);
		add_op(4'd12, 63, 63);
		add_op(4'd15, 0, 0);
		add_op(MODE_CLEAR, 0, 0);
		wait_drain();

		// Random phases with different idle and stall mixes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			// Fill the pool in the first phase to reach the count limit
			if (ph == 0) begin
				for (int i = 0; i < POOL_NODES; i++) add_op(MODE_INS_TAIL, i, 0);
				add_op(MODE_PEEK_TAIL, 0, 0);
				add_op(MODE_CLEAR, 0, 0);
			end
			for (int i = 0; i < 300; i++) add_random_op();
			wait_drain();
		end

		$display("Ran %0d items through all twelve list operations and unused modes,", ops_sent);
		$display("with %0d results checked across idle and stall mixes.", answers_seen);
		if (mismatch_count == 0 && expected_answers.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
src/dllm_pkg.sv
src/dllm_ram.sv
src/dllm_front.sv
src/dllm_back.sv
src/doubly_linked_list_manager_top.sv
src/dllm_checker.sv
test/doubly_linked_list_manager_top_tb.sv
